// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the byte budget LRU directory.
// Each macro expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define BLC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion lbl failed");

// Next-cycle implication, quiet during reset.
`define BLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion lbl failed");

`endif

// File: hdl/blc_pkg.sv
// Types, codes and constants of the byte budget LRU directory.
// No dependencies.
`default_nettype none
package blc_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int KEY_W       = 64;
  localparam int GROUP_W     = 16;
  localparam int SIZE_W      = 40;
  localparam int BYTES_W     = 48;
  localparam int CNT_W       = 32;

  localparam logic [2:0] KIND_PUT   = 3'd0;
  localparam logic [2:0] KIND_GET   = 3'd1;
  localparam logic [2:0] KIND_EKEY  = 3'd2;
  localparam logic [2:0] KIND_EGRP  = 3'd3;
  localparam logic [2:0] KIND_CLEAR = 3'd4;

  localparam logic [2:0] ST_STORED  = 3'd0;
  localparam logic [2:0] ST_HIT     = 3'd1;
  localparam logic [2:0] ST_MISS    = 3'd2;
  localparam logic [2:0] ST_REMOVED = 3'd3;
  localparam logic [2:0] ST_STALE   = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;

  typedef struct packed {
    logic [2:0]         kind;
    logic [KEY_W-1:0]   key;
    logic [GROUP_W-1:0] group;
    logic [SIZE_W-1:0]  entry_size;
    logic               still_valid;
  } blc_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         slot;
    logic [KEY_W-1:0]   removed_key;
    logic [BYTES_W-1:0] bytes_used;
    logic [CNT_W-1:0]   hits;
    logic [CNT_W-1:0]   misses;
    logic [CNT_W-1:0]   evictions;
    logic               last;
  } blc_out_t;

  typedef enum logic [1:0] {OP_NONE, OP_DROP, OP_PROMOTE, OP_INSERT} blc_op_t;

  typedef enum logic [2:0] {
    FIND_NONE, FIND_KEY, FIND_GROUP, FIND_PRESENT, FIND_FREE, FIND_TAIL
  } blc_find_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    blc_op_t            op;
    blc_find_t          find;
    logic [KEY_W-1:0]   key;
    logic [GROUP_W-1:0] group;
    logic [SIZE_W-1:0]  size;
  } blc_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DUP, S_EVICT, S_STORE, S_GET, S_STALE, S_KEY, S_GROUP, S_CLEAR, S_DONE
  } blc_state_t;

endpackage
`default_nettype wire

// File: hdl/blc_cell.sv
// One directory slot: tag, group, size, present flag and recency rank.
// Depends on blc_pkg. Passes the priority-select carry to its right neighbor.
`default_nettype none
module blc_cell import blc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int INDEX   = 0,
  localparam int IW     = $clog2(ENTRIES)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire blc_cmd_t         cmd,
  input  wire logic [IW-1:0]    tgt_idx,
  input  wire logic [IW-1:0]    tgt_rank,
  input  wire logic [IW-1:0]    tail_rank,
  input  wire logic             taken_in,
  output logic                  taken_out,
  output logic                  pick,
  output logic                  present,
  output logic [IW-1:0]         rank,
  output logic [KEY_W-1:0]      tag,
  output logic [SIZE_W-1:0]     nbytes
);

  logic [GROUP_W-1:0] grp;
  logic               want;
  logic               me;

  assign me = (tgt_idx == IW'(INDEX));

  always_comb begin
    case (cmd.find)
      FIND_KEY:     want = present && (tag == cmd.key);
      FIND_GROUP:   want = present && (grp == cmd.group);
      FIND_PRESENT: want = present;
      FIND_FREE:    want = !present;
      FIND_TAIL:    want = present && (rank == tail_rank);
      default:      want = 1'b0;
    endcase
  end

  // lowest-numbered wanting cell wins
  assign pick      = want && !taken_in;
  assign taken_out = taken_in || want;

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= 1'b0;
      rank    <= IW'(INDEX);
    end else begin
      case (cmd.op)
        OP_DROP: begin
          if (me) begin
            present <= 1'b0;
            rank    <= IW'(ENTRIES - 1);
          end else if (rank > tgt_rank) begin
            rank <= rank - IW'(1);
          end
        end
        OP_PROMOTE, OP_INSERT: begin
          if (me) begin
            rank <= '0;
            if (cmd.op == OP_INSERT) present <= 1'b1;
          end else if (rank < tgt_rank) begin
            rank <= rank + IW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_INSERT && me) begin
      tag    <= cmd.key;
      grp    <= cmd.group;
      nbytes <= cmd.size;
    end
  end

endmodule
`default_nettype wire

// File: hdl/byte_budget_lru_cache.sv
// Top level of the byte budget LRU directory: APB register, controller, cell row.
// Depends on blc_pkg, blc_cell and assert_macros.svh.
//
//  channel  | signals                        | transfer when
//  ---------+--------------------------------+-------------------------------
//  config   | psel penable pwrite paddr ...  | psel & penable & pwrite
//  request  | start cmd busy                 | start & !busy
//  result   | valid result                   | valid (one cycle, no stall)
//
// An accepted request keeps busy high while it emits its result items and during
// each check that emits nothing: the duplicate-key check of a put that replaces
// no key, and the final budget check of a put unless its last eviction was for
// a full table. The next request can be accepted at the end of the cycle that
// presents the last result.
// Evictions, group and clear sweeps walk the cell row one slot per cycle.
// Reset is synchronous; the cells come out empty with rank = slot.
// The result side cannot stall; only the checks that emit nothing leave gaps between results.
`default_nettype none
`include "assert_macros.svh"
module byte_budget_lru_cache import blc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  input  wire logic        start,
  input  wire blc_in_t     cmd,
  output logic             busy,
  output logic             valid,
  output blc_out_t         result
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  // ---- configuration register
  logic [BYTES_W-1:0] budget;

  assign pready = 1'b1;
  assign prdata = paddr[3] ? 64'd0 : {16'd0, budget};

  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= '0;
    end else if (psel && penable && pwrite && pready && !paddr[3]) begin
      budget <= pwdata[BYTES_W-1:0];
    end
  end

  // ---- state
  blc_state_t         state, state_next;
  blc_in_t            req;
  logic [CW-1:0]      count, count_next;
  logic [BYTES_W-1:0] used, used_next;
  logic [CNT_W-1:0]   hits, hits_next, misses, misses_next, evicts, evicts_next;

  // ---- cell row
  blc_cmd_t            ccmd;
  logic [IW-1:0]       tgt_idx, tgt_rank, tail_rank;
  logic [CW-1:0]       cnt_m1;
  logic [ENTRIES:0]    taken;
  logic [ENTRIES-1:0]  pick, present_vec;
  logic [IW-1:0]       rank_a [ENTRIES];
  logic [KEY_W-1:0]    tag_a  [ENTRIES];
  logic [SIZE_W-1:0]   size_a [ENTRIES];

  assign cnt_m1    = count - CW'(1);
  assign tail_rank = cnt_m1[IW-1:0];
  assign taken[0]  = 1'b0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    blc_cell #(.ENTRIES(ENTRIES), .INDEX(g)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (ccmd),
      .tgt_idx   (tgt_idx),
      .tgt_rank  (tgt_rank),
      .tail_rank (tail_rank),
      .taken_in  (taken[g]),
      .taken_out (taken[g+1]),
      .pick      (pick[g]),
      .present   (present_vec[g]),
      .rank      (rank_a[g]),
      .tag       (tag_a[g]),
      .nbytes    (size_a[g])
    );
  end

  // selected cell's contents, one-hot OR
  logic [IW-1:0]     sel_idx, sel_rank;
  logic [KEY_W-1:0]  sel_tag;
  logic [SIZE_W-1:0] sel_size;
  logic              found;
  logic [IW+3:0]     sel_ext;

  assign found = taken[ENTRIES];

  always_comb begin
    sel_idx  = '0;
    sel_rank = '0;
    sel_tag  = '0;
    sel_size = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (pick[i]) begin
        sel_idx  = sel_idx  | IW'(i);
        sel_rank = sel_rank | rank_a[i];
        sel_tag  = sel_tag  | tag_a[i];
        sel_size = sel_size | size_a[i];
      end
    end
  end

  assign sel_ext = {4'd0, sel_idx};

  // ---- byte arithmetic
  logic [BYTES_W:0]   used_plus;
  logic [BYTES_W-1:0] used_minus;
  logic               over;

  assign used_plus  = {1'b0, used} + (BYTES_W + 1)'(req.entry_size);
  assign used_minus = (used >= BYTES_W'(sel_size)) ? used - BYTES_W'(sel_size) : '0;
  assign over       = (count != '0) && (used_plus > {1'b0, budget});

  // ---- controller
  logic       emit, r_last;
  logic [2:0] r_status;
  logic [3:0] r_slot;
  logic [KEY_W-1:0] r_key;

  always_comb begin
    state_next  = state;
    count_next  = count;
    used_next   = used;
    hits_next   = hits;
    misses_next = misses;
    evicts_next = evicts;
    ccmd.op     = OP_NONE;
    ccmd.find   = FIND_NONE;
    ccmd.key    = req.key;
    ccmd.group  = req.group;
    ccmd.size   = req.entry_size;
    tgt_idx     = sel_idx;
    tgt_rank    = sel_rank;
    emit        = 1'b0;
    r_status    = ST_DONE;
    r_slot      = '0;
    r_key       = '0;
    r_last      = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (cmd.kind)
            KIND_PUT:   state_next = S_DUP;
            KIND_GET:   state_next = S_GET;
            KIND_EKEY:  state_next = S_KEY;
            KIND_EGRP:  state_next = S_GROUP;
            KIND_CLEAR: state_next = S_CLEAR;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_DUP: begin
        ccmd.find  = FIND_KEY;
        state_next = S_EVICT;
        if (found) begin
          ccmd.op    = OP_DROP;
          count_next = count - CW'(1);
          used_next  = used_minus;
          emit       = 1'b1;
          r_status   = ST_REMOVED;
          r_slot     = sel_ext[3:0];
          r_key      = sel_tag;
        end
      end
      S_EVICT: begin
        ccmd.find = FIND_TAIL;
        if (over || count == CW'(ENTRIES)) begin
          ccmd.op     = OP_DROP;
          count_next  = count - CW'(1);
          used_next   = used_minus;
          evicts_next = evicts + CNT_W'(1);
          emit        = 1'b1;
          r_status    = ST_REMOVED;
          r_slot      = sel_ext[3:0];
          r_key       = sel_tag;
          if (!over) state_next = S_STORE;
        end else begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        ccmd.find  = FIND_FREE;
        ccmd.op    = OP_INSERT;
        count_next = count + CW'(1);
        used_next  = used_plus[BYTES_W] ? '1 : used_plus[BYTES_W-1:0];
        emit       = 1'b1;
        r_status   = ST_STORED;
        r_slot     = sel_ext[3:0];
        r_last     = 1'b1;
        state_next = S_IDLE;
      end
      S_GET: begin
        ccmd.find = FIND_KEY;
        emit      = 1'b1;
        if (!found) begin
          misses_next = misses + CNT_W'(1);
          r_status    = ST_MISS;
          r_last      = 1'b1;
          state_next  = S_IDLE;
        end else if (!req.still_valid) begin
          ccmd.op     = OP_DROP;
          count_next  = count - CW'(1);
          used_next   = used_minus;
          misses_next = misses + CNT_W'(1);
          r_status    = ST_REMOVED;
          r_slot      = sel_ext[3:0];
          r_key       = sel_tag;
          state_next  = S_STALE;
        end else begin
          ccmd.op    = OP_PROMOTE;
          hits_next  = hits + CNT_W'(1);
          r_status   = ST_HIT;
          r_slot     = sel_ext[3:0];
          r_last     = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_STALE: begin
        emit       = 1'b1;
        r_status   = ST_STALE;
        r_last     = 1'b1;
        state_next = S_IDLE;
      end
      S_KEY: begin
        ccmd.find = FIND_KEY;
        if (found) begin
          ccmd.op     = OP_DROP;
          count_next  = count - CW'(1);
          used_next   = used_minus;
          evicts_next = evicts + CNT_W'(1);
          emit        = 1'b1;
          r_status    = ST_REMOVED;
          r_slot      = sel_ext[3:0];
          r_key       = sel_tag;
          state_next  = S_DONE;
        end else begin
          emit       = 1'b1;
          r_last     = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_GROUP, S_CLEAR: begin
        ccmd.find = (state == S_GROUP) ? FIND_GROUP : FIND_PRESENT;
        emit      = 1'b1;
        if (found) begin
          ccmd.op    = OP_DROP;
          count_next = count - CW'(1);
          used_next  = used_minus;
          if (state == S_GROUP) evicts_next = evicts + CNT_W'(1);
          r_status   = ST_REMOVED;
          r_slot     = sel_ext[3:0];
          r_key      = sel_tag;
        end else begin
          if (state == S_CLEAR) used_next = '0;
          r_last     = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DONE: begin
        emit       = 1'b1;
        r_last     = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      used   <= '0;
      hits   <= '0;
      misses <= '0;
      evicts <= '0;
      valid  <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      used   <= used_next;
      hits   <= hits_next;
      misses <= misses_next;
      evicts <= evicts_next;
      valid  <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) req <= cmd;
    if (emit) begin
      result.status      <= r_status;
      result.slot        <= r_slot;
      result.removed_key <= r_key;
      result.bytes_used  <= used_next;
      result.hits        <= hits_next;
      result.misses      <= misses_next;
      result.evictions   <= evicts_next;
      result.last        <= r_last;
    end
  end

  assign busy = (state != S_IDLE);

  // ---- checks
  `BLC_ASSERT_IMPL(a_fill_count, 1'b1, $countones(present_vec) == int'(count))
  `BLC_ASSERT_IMPL(a_last_idle, valid && result.last, !busy)
  `BLC_ASSERT_NEXT(a_no_early_result, start && !busy, !valid)

endmodule
`default_nettype wire
